// ===== rtl/sdprobe_pkg.sv =====
// Shared constants and widths for the SD/MMC card probe sequencer.
// No dependencies; imported by the top level.
`default_nettype none

package sdprobe_pkg;

  localparam int LimitWidth   = 7;
  localparam int VoltWidth    = 24;
  localparam int WordWidth    = 32;
  localparam int IndexWidth   = 6;
  localparam int KindWidth    = 2;
  localparam int TypeWidth    = 3;
  localparam int AddrWidth    = 16;
  localparam int InDataWidth  = 40;
  localparam int OutDataWidth = 64;

  localparam logic [LimitWidth-1:0] LimitReset = 7'd100;
  localparam logic [VoltWidth-1:0]  VoltReset  = 24'h200000;

  localparam logic [WordWidth-1:0] HcsBit  = 32'h4000_0000;
  localparam logic [7:0]           CheckPattern = 8'haa;
  localparam logic [AddrWidth-1:0] MmcRca  = 16'h0001;

  // Input item kinds (carried on tuser).
  localparam logic OpStart    = 1'b0;
  localparam logic OpFinished = 1'b1;

  // Configuration register indexes.
  localparam logic CfgAttemptLimit  = 1'b0;
  localparam logic CfgVoltageWindow = 1'b1;

  // Command indexes.
  localparam logic [IndexWidth-1:0] CmdGoIdle  = 6'd0;
  localparam logic [IndexWidth-1:0] CmdSendOp  = 6'd1;
  localparam logic [IndexWidth-1:0] CmdAllCid  = 6'd2;
  localparam logic [IndexWidth-1:0] CmdRca     = 6'd3;
  localparam logic [IndexWidth-1:0] CmdSelect  = 6'd7;
  localparam logic [IndexWidth-1:0] CmdIfCond  = 6'd8;
  localparam logic [IndexWidth-1:0] CmdCsd     = 6'd9;
  localparam logic [IndexWidth-1:0] CmdAppOp   = 6'd41;
  localparam logic [IndexWidth-1:0] CmdAppCmd  = 6'd55;

  // Response kinds.
  localparam logic [KindWidth-1:0] RespNone  = 2'd0;
  localparam logic [KindWidth-1:0] RespShort = 2'd1;
  localparam logic [KindWidth-1:0] RespCrc   = 2'd2;
  localparam logic [KindWidth-1:0] RespLong  = 2'd3;

  // Card types.
  localparam logic [TypeWidth-1:0] TypeNone = 3'd0;
  localparam logic [TypeWidth-1:0] TypeMmc  = 3'd1;
  localparam logic [TypeWidth-1:0] TypeSd   = 3'd2;
  localparam logic [TypeWidth-1:0] TypeSdV2 = 3'd3;
  localparam logic [TypeWidth-1:0] TypeSdhc = 3'd4;

  typedef struct packed {
    logic                  issue;
    logic [IndexWidth-1:0] cmd_index;
    logic [WordWidth-1:0]  cmd_arg;
    logic [KindWidth-1:0]  response_kind;
    logic                  finished;
    logic                  success;
  } command_t;

endpackage

`default_nettype wire

// ===== rtl/sd_mmc_card_probe_sequencer_unit.sv =====
// Top level of the SD/MMC card probe sequencer: input register, next-command
// logic, probe state and result register. Depends on sdprobe_pkg.
`default_nettype none

// The block takes one item per clock while the output side is not stalled,
// and returns exactly one result per item once the item has passed through
// the input register and then the result register. Throughput is one item
// per cycle while the output is not stalled, set by the probe state update,
// which is combinational between the input register and the result register.
// A start item restarts the probe at any time and yields CMD0; each
// command-finished item yields the next command to send, the end of the
// probe, or, while idle, neither. Configuration writes take effect on the
// next clock edge and should be made while no item is in flight.
module sd_mmc_card_probe_sequencer_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic                                  cfg_index,
  input  wire logic [sdprobe_pkg::VoltWidth-1:0]     cfg_data,
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  // [0] timed_out, [1] crc_failed, [33:2] resp_word, [39:34] zero
  input  wire logic [sdprobe_pkg::InDataWidth-1:0]   s_tdata,
  // [0] opcode
  input  wire logic                                  s_tuser,
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  // [0] issue, [6:1] cmd_index, [38:7] cmd_arg, [40:39] response_kind,
  // [41] finished, [42] success, [45:43] card_type, [61:46] card_address,
  // [63:62] zero
  output logic [sdprobe_pkg::OutDataWidth-1:0]       m_tdata
);
  import sdprobe_pkg::*;

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_RST_A  = 4'd1;
  localparam logic [3:0] PH_RST_B  = 4'd2;
  localparam logic [3:0] PH_RST_C  = 4'd3;
  localparam logic [3:0] PH_RST_D  = 4'd4;
  localparam logic [3:0] PH_IFCOND = 4'd5;
  localparam logic [3:0] PH_APP    = 4'd6;
  localparam logic [3:0] PH_SDOP   = 4'd7;
  localparam logic [3:0] PH_MMCOP  = 4'd8;
  localparam logic [3:0] PH_CID    = 4'd9;
  localparam logic [3:0] PH_RCA    = 4'd10;
  localparam logic [3:0] PH_CSD    = 4'd11;
  localparam logic [3:0] PH_SEL    = 4'd12;
  localparam logic [3:0] PH_DESEL  = 4'd13;

  // Configuration registers.
  logic [LimitWidth-1:0] attempt_limit;
  logic [VoltWidth-1:0]  voltage_window;

  // Input register.
  logic                 in_valid;
  logic                 in_opcode;
  logic                 in_timed_out;
  logic                 in_crc_failed;
  logic [WordWidth-1:0] in_resp;

  // Probe state.
  logic [3:0]            phase, phase_next;
  logic                  second_try, second_try_next;
  logic [LimitWidth-1:0] attempts, attempts_next;
  logic [TypeWidth-1:0]  found_type, found_type_next;
  logic [AddrWidth-1:0]  found_address, found_address_next;

  command_t              cmd;
  logic                  advance;
  logic                  ok_plain, ok_crc;
  logic [LimitWidth-1:0] eff_limit;
  logic [LimitWidth-1:0] attempts_inc;
  logic                  limit_hit;
  logic [AddrWidth-1:0]  rca_addr;
  logic [WordWidth-1:0]  volt_arg;

  // Result register.
  command_t              res_cmd;
  logic [TypeWidth-1:0]  res_type;
  logic [AddrWidth-1:0]  res_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      attempt_limit  <= LimitReset;
      voltage_window <= VoltReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgAttemptLimit:  attempt_limit  <= cfg_data[LimitWidth-1:0];
        CfgVoltageWindow: voltage_window <= cfg_data;
        default: ;
      endcase
    end
  end

  // The result register frees up whenever its transfer completes, so the
  // input register moves on in the same cycle.
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_opcode     <= s_tuser;
      in_timed_out  <= s_tdata[0];
      in_crc_failed <= s_tdata[1];
      in_resp       <= s_tdata[WordWidth+1:2];
    end
  end

  assign ok_plain     = !in_timed_out;
  assign ok_crc       = !in_timed_out && !in_crc_failed;
  assign eff_limit    = (attempt_limit == '0) ? LimitWidth'(1) : attempt_limit;
  assign attempts_inc = attempts + LimitWidth'(1);
  assign limit_hit    = attempts_inc >= eff_limit;
  assign rca_addr     = (found_type != TypeMmc) ? in_resp[WordWidth-1:AddrWidth]
                                                : found_address;
  assign volt_arg     = {{(WordWidth-VoltWidth){1'b0}}, voltage_window};

  always_comb begin
    phase_next         = phase;
    second_try_next    = second_try;
    attempts_next      = attempts;
    found_type_next    = found_type;
    found_address_next = found_address;
    cmd                = '0;

    if (in_opcode == OpStart) begin
      attempts_next      = '0;
      found_type_next    = TypeNone;
      found_address_next = '0;
      second_try_next    = 1'b0;
      phase_next         = PH_RST_A;
      cmd.issue          = 1'b1;
      cmd.cmd_index      = CmdGoIdle;
    end else begin
      unique case (phase)
        PH_RST_A, PH_RST_B, PH_RST_C, PH_RST_D: begin
          cmd.issue = 1'b1;
          if (ok_plain) begin
            second_try_next = 1'b0;
            unique case (phase)
              PH_RST_A: begin
                phase_next    = PH_RST_B;
                cmd.cmd_index = CmdGoIdle;
              end
              PH_RST_B: begin
                phase_next        = PH_IFCOND;
                cmd.cmd_index     = CmdIfCond;
                cmd.cmd_arg       = volt_arg;
                cmd.response_kind = RespCrc;
              end
              PH_RST_C: begin
                attempts_next     = '0;
                phase_next        = PH_APP;
                cmd.cmd_index     = CmdAppCmd;
                cmd.response_kind = RespShort;
              end
              default: begin
                attempts_next     = '0;
                phase_next        = PH_MMCOP;
                cmd.cmd_index     = CmdSendOp;
                cmd.cmd_arg       = volt_arg | HcsBit;
                cmd.response_kind = RespShort;
              end
            endcase
          end else if (!second_try) begin
            // First timeout of CMD0: send it once more in the same phase.
            second_try_next = 1'b1;
            cmd.cmd_index   = CmdGoIdle;
          end else begin
            second_try_next = 1'b0;
            cmd.cmd_index   = CmdGoIdle;
            if (phase == PH_RST_B) begin
              phase_next = PH_RST_C;
            end else if (phase == PH_RST_C) begin
              phase_next = PH_RST_D;
            end else begin
              cmd.issue    = 1'b0;
              phase_next   = PH_IDLE;
              cmd.finished = 1'b1;
            end
          end
        end
        PH_IFCOND: begin
          found_type_next = (ok_crc && in_resp[7:0] == CheckPattern) ? TypeSdV2 : TypeNone;
          second_try_next = 1'b0;
          phase_next      = PH_RST_C;
          cmd.issue       = 1'b1;
          cmd.cmd_index   = CmdGoIdle;
        end
        PH_APP, PH_SDOP: begin
          cmd.issue = 1'b1;
          if (phase == PH_APP && ok_plain && in_resp[5] && !in_resp[22]) begin
            phase_next        = PH_SDOP;
            cmd.cmd_index     = CmdAppOp;
            cmd.cmd_arg       = volt_arg | ((found_type == TypeSdV2) ? HcsBit : '0);
            cmd.response_kind = RespShort;
          end else if (phase == PH_SDOP && ok_plain && in_resp[31]) begin
            if (in_resp[30]) begin
              found_type_next = TypeSdhc;
            end else if (found_type != TypeSdV2) begin
              found_type_next = TypeSd;
            end
            phase_next        = PH_CID;
            cmd.cmd_index     = CmdAllCid;
            cmd.response_kind = RespLong;
          end else begin
            attempts_next = attempts_inc;
            if (limit_hit) begin
              // SD polling exhausted: fall back to the MMC reset.
              found_type_next = TypeNone;
              second_try_next = 1'b0;
              phase_next      = PH_RST_D;
              cmd.cmd_index   = CmdGoIdle;
            end else begin
              phase_next        = PH_APP;
              cmd.cmd_index     = CmdAppCmd;
              cmd.response_kind = RespShort;
            end
          end
        end
        PH_MMCOP: begin
          if (ok_plain && in_resp[31]) begin
            found_type_next   = TypeMmc;
            phase_next        = PH_CID;
            cmd.issue         = 1'b1;
            cmd.cmd_index     = CmdAllCid;
            cmd.response_kind = RespLong;
          end else begin
            attempts_next = attempts_inc;
            if (limit_hit) begin
              found_type_next = TypeNone;
              phase_next      = PH_IDLE;
              cmd.finished    = 1'b1;
            end else begin
              cmd.issue         = 1'b1;
              cmd.cmd_index     = CmdSendOp;
              cmd.cmd_arg       = volt_arg | HcsBit;
              cmd.response_kind = RespShort;
            end
          end
        end
        PH_CID: begin
          if (!ok_crc) begin
            phase_next   = PH_IDLE;
            cmd.finished = 1'b1;
          end else if (found_type == TypeMmc) begin
            found_address_next = MmcRca;
            phase_next         = PH_RCA;
            cmd.issue          = 1'b1;
            cmd.cmd_index      = CmdRca;
            cmd.cmd_arg        = {MmcRca, {(WordWidth-AddrWidth){1'b0}}};
            cmd.response_kind  = RespCrc;
          end else if (found_type == TypeSd || found_type == TypeSdV2 ||
                       found_type == TypeSdhc) begin
            phase_next        = PH_RCA;
            cmd.issue         = 1'b1;
            cmd.cmd_index     = CmdRca;
            cmd.response_kind = RespCrc;
          end else begin
            found_address_next = '0;
            phase_next         = PH_IDLE;
            cmd.finished       = 1'b1;
          end
        end
        PH_RCA: begin
          if (!ok_crc) begin
            phase_next   = PH_IDLE;
            cmd.finished = 1'b1;
          end else begin
            found_address_next = rca_addr;
            phase_next         = PH_CSD;
            cmd.issue          = 1'b1;
            cmd.cmd_index      = CmdCsd;
            cmd.cmd_arg        = {rca_addr, {(WordWidth-AddrWidth){1'b0}}};
            cmd.response_kind  = RespLong;
          end
        end
        PH_CSD: begin
          if (!ok_crc) begin
            phase_next   = PH_IDLE;
            cmd.finished = 1'b1;
          end else begin
            phase_next        = PH_SEL;
            cmd.issue         = 1'b1;
            cmd.cmd_index     = CmdSelect;
            cmd.cmd_arg       = {found_address, {(WordWidth-AddrWidth){1'b0}}};
            cmd.response_kind = RespCrc;
          end
        end
        PH_SEL: begin
          if (!ok_crc) begin
            phase_next   = PH_IDLE;
            cmd.finished = 1'b1;
          end else begin
            phase_next        = PH_DESEL;
            cmd.issue         = 1'b1;
            cmd.cmd_index     = CmdSelect;
            cmd.response_kind = RespCrc;
          end
        end
        PH_DESEL: begin
          phase_next   = PH_IDLE;
          cmd.finished = 1'b1;
          cmd.success  = ok_crc;
        end
        default: begin
          // Idle, or an unused encoding: completions are ignored.
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      second_try    <= 1'b0;
      attempts      <= '0;
      found_type    <= TypeNone;
      found_address <= '0;
      m_tvalid      <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
      if (in_valid) begin
        phase         <= phase_next;
        second_try    <= second_try_next;
        attempts      <= attempts_next;
        found_type    <= found_type_next;
        found_address <= found_address_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      res_cmd  <= cmd;
      res_type <= found_type_next;
      res_addr <= found_address_next;
    end
  end

  assign m_tdata = {2'b00, res_addr, res_type, res_cmd.success, res_cmd.finished,
                    res_cmd.response_kind, res_cmd.cmd_arg, res_cmd.cmd_index,
                    res_cmd.issue};

  // A result either names a command or ends the probe, never both.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(res_cmd.issue && res_cmd.finished))
    else $error("result both issues a command and finishes the probe");

  // Success is only reported on the final result of a probe.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res_cmd.success |-> res_cmd.finished && res_type != TypeNone)
    else $error("success reported without a finished probe and a card type");

  // A finished probe leaves the sequencer idle.
  assert property (@(posedge clk) disable iff (rst)
    advance && in_valid && cmd.finished |=> phase == PH_IDLE)
    else $error("probe finished but phase is not idle");

  // The polling counter never passes the effective attempt limit.
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_APP || phase == PH_SDOP || phase == PH_MMCOP) |-> attempts < eff_limit)
    else $error("polling attempts exceed the limit");

endmodule

`default_nettype wire

// ===== tb/sv/tb_sd_mmc_card_probe_sequencer_unit.sv =====
// Self-checking testbench for the SD/MMC card probe sequencer: a card responder
// feeds command completions, and an in-line predictor checks every result.
// Depends on sdprobe_pkg and sd_mmc_card_probe_sequencer_unit.
`timescale 1ns / 100ps

module tb_sd_mmc_card_probe_sequencer_unit;
  import sdprobe_pkg::*;

  typedef enum logic [4:0] {
    PhIdle, PhRstA, PhRstB, PhRstC, PhRstD, PhIfCond, PhApp, PhSdOp, PhMmcOp,
    PhCid, PhRca, PhCsd, PhSel, PhDesel
  } probe_phase_t;

  typedef struct packed {
    probe_phase_t   ph;
    logic           second_try;
    logic [6:0]     attempts;
    logic [2:0]     ctype;
    logic [15:0]    addr;
  } probe_state_t;

  typedef struct packed {
    logic [6:0]  limit;
    logic [23:0] volt;
  } probe_cfg_t;

  typedef struct packed {
    logic        opcode;
    logic        timed_out;
    logic        crc_failed;
    logic [31:0] resp;
  } probe_item_t;

  typedef struct packed {
    logic        issue;
    logic [5:0]  idx;
    logic [31:0] arg;
    logic [1:0]  kind;
    logic        finished;
    logic        success;
    logic [2:0]  ctype;
    logic [15:0] addr;
  } probe_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [23:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;

  probe_state_t  gen_state;
  probe_state_t  dut_state;
  probe_cfg_t    cur_cfg;
  probe_result_t last_plan;
  probe_item_t   pending_items[$];
  probe_result_t expected_cmds[$];

  logic gaps_on = 1'b1;
  logic took_item = 1'b0;
  int   errors = 0;
  int   items_pushed = 0;
  int   items_taken = 0;
  int   results_seen = 0;
  int   probes_ok = 0;
  int   probes_failed = 0;
  int   settings_used = 1;

  sd_mmc_card_probe_sequencer_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic probe_result_t cmd_out(logic [5:0] idx, logic [31:0] arg,
                                            logic [1:0] kind);
    probe_result_t r;
    r = '0;
    r.issue = 1'b1;
    r.idx = idx;
    r.arg = arg;
    r.kind = kind;
    return r;
  endfunction

  // One failed SD polling attempt: retry with CMD55, or fall back to the
  // CMD1 route once the attempts are used up.
  function automatic probe_result_t sd_retry(inout probe_state_t st, input logic [6:0] lim);
    probe_result_t r;
    st.attempts = st.attempts + 7'd1;
    if (st.attempts >= lim) begin
      st.ctype = TypeNone;
      st.second_try = 1'b0;
      st.ph = PhRstD;
      r = cmd_out(CmdGoIdle, '0, RespNone);
    end else begin
      st.ph = PhApp;
      r = cmd_out(CmdAppCmd, '0, RespShort);
    end
    return r;
  endfunction

  function automatic probe_result_t next_probe_step(inout probe_state_t st,
                                                    input probe_cfg_t cfg,
                                                    input probe_item_t it);
    probe_result_t res;
    logic          ok_plain;
    logic          ok_crc;
    logic [6:0]    lim;
    logic [31:0]   volt_arg;
    res = '0;
    ok_plain = !it.timed_out;
    ok_crc = !it.timed_out && !it.crc_failed;
    lim = (cfg.limit == 7'd0) ? 7'd1 : cfg.limit;
    volt_arg = {8'h00, cfg.volt};
    if (it.opcode == OpStart) begin
      st.attempts = '0;
      st.ctype = TypeNone;
      st.addr = '0;
      st.second_try = 1'b0;
      st.ph = PhRstA;
      res = cmd_out(CmdGoIdle, '0, RespNone);
    end else begin
      case (st.ph)
        PhRstA, PhRstB, PhRstC, PhRstD: begin
          if (ok_plain) begin
            st.second_try = 1'b0;
            case (st.ph)
              PhRstA: begin
                st.ph = PhRstB;
                res = cmd_out(CmdGoIdle, '0, RespNone);
              end
              PhRstB: begin
                st.ph = PhIfCond;
                res = cmd_out(CmdIfCond, volt_arg, RespCrc);
              end
              PhRstC: begin
                st.attempts = '0;
                st.ph = PhApp;
                res = cmd_out(CmdAppCmd, '0, RespShort);
              end
              default: begin
                st.attempts = '0;
                st.ph = PhMmcOp;
                res = cmd_out(CmdSendOp, volt_arg | HcsBit, RespShort);
              end
            endcase
          end else if (!st.second_try) begin
            st.second_try = 1'b1;
            res = cmd_out(CmdGoIdle, '0, RespNone);
          end else begin
            st.second_try = 1'b0;
            if (st.ph == PhRstB) begin
              st.ph = PhRstC;
              res = cmd_out(CmdGoIdle, '0, RespNone);
            end else if (st.ph == PhRstC) begin
              st.ph = PhRstD;
              res = cmd_out(CmdGoIdle, '0, RespNone);
            end else begin
              st.ph = PhIdle;
              res.finished = 1'b1;
            end
          end
        end
        PhIfCond: begin
          st.ctype = (ok_crc && it.resp[7:0] == CheckPattern) ? TypeSdV2 : TypeNone;
          st.second_try = 1'b0;
          st.ph = PhRstC;
          res = cmd_out(CmdGoIdle, '0, RespNone);
        end
        PhApp: begin
          if (ok_plain && it.resp[5] && !it.resp[22]) begin
            st.ph = PhSdOp;
            res = cmd_out(CmdAppOp, volt_arg | ((st.ctype == TypeSdV2) ? HcsBit : '0),
                          RespShort);
          end else begin
            res = sd_retry(st, lim);
          end
        end
        PhSdOp: begin
          if (ok_plain && it.resp[31]) begin
            if (it.resp[30]) st.ctype = TypeSdhc;
            else if (st.ctype != TypeSdV2) st.ctype = TypeSd;
            st.ph = PhCid;
            res = cmd_out(CmdAllCid, '0, RespLong);
          end else begin
            res = sd_retry(st, lim);
          end
        end
        PhMmcOp: begin
          if (ok_plain && it.resp[31]) begin
            st.ctype = TypeMmc;
            st.ph = PhCid;
            res = cmd_out(CmdAllCid, '0, RespLong);
          end else begin
            st.attempts = st.attempts + 7'd1;
            if (st.attempts >= lim) begin
              st.ctype = TypeNone;
              st.ph = PhIdle;
              res.finished = 1'b1;
            end else begin
              res = cmd_out(CmdSendOp, volt_arg | HcsBit, RespShort);
            end
          end
        end
        PhCid: begin
          if (!ok_crc) begin
            st.ph = PhIdle;
            res.finished = 1'b1;
          end else if (st.ctype == TypeMmc) begin
            st.addr = MmcRca;
            st.ph = PhRca;
            res = cmd_out(CmdRca, {MmcRca, 16'h0000}, RespCrc);
          end else if (st.ctype >= TypeSd && st.ctype <= TypeSdhc) begin
            st.ph = PhRca;
            res = cmd_out(CmdRca, '0, RespCrc);
          end else begin
            st.addr = '0;
            st.ph = PhIdle;
            res.finished = 1'b1;
          end
        end
        PhRca: begin
          if (!ok_crc) begin
            st.ph = PhIdle;
            res.finished = 1'b1;
          end else begin
            if (st.ctype != TypeMmc) st.addr = it.resp[31:16];
            st.ph = PhCsd;
            res = cmd_out(CmdCsd, {st.addr, 16'h0000}, RespLong);
          end
        end
        PhCsd: begin
          if (!ok_crc) begin
            st.ph = PhIdle;
            res.finished = 1'b1;
          end else begin
            st.ph = PhSel;
            res = cmd_out(CmdSelect, {st.addr, 16'h0000}, RespCrc);
          end
        end
        PhSel: begin
          if (!ok_crc) begin
            st.ph = PhIdle;
            res.finished = 1'b1;
          end else begin
            st.ph = PhDesel;
            res = cmd_out(CmdSelect, '0, RespCrc);
          end
        end
        PhDesel: begin
          st.ph = PhIdle;
          res.finished = 1'b1;
          res.success = ok_crc;
        end
        default: st.ph = PhIdle;
      endcase
    end
    res.ctype = st.ctype;
    res.addr = st.addr;
    return res;
  endfunction

  task automatic flag_mismatch(input string what);
    errors++;
    $display("ERROR at %0t: %s", $realtime, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                              results_seen, name, got, want));
  endtask

  // Input side: a new item goes out at the falling edge after the previous
  // transfer, unless no item is pending or this cycle is chosen as a gap.
  always @(negedge clk) begin : feed
    probe_item_t nxt;
    if (!rst && (!s_tvalid || took_item)) begin
      if (pending_items.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 34)) begin
        nxt = pending_items.pop_front();
        s_tdata <= {6'b000000, nxt.resp, nxt.crc_failed, nxt.timed_out};
        s_tuser <= nxt.opcode;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    m_tready <= !rst && (!gaps_on || $urandom_range(0, 99) >= 34);
  end

  always @(posedge clk) begin : watch
    probe_item_t   it;
    probe_result_t want;
    probe_result_t got;
    took_item = s_tvalid && s_tready;
    if (!rst) begin
      if (took_item) begin
        it.opcode = s_tuser;
        it.timed_out = s_tdata[0];
        it.crc_failed = s_tdata[1];
        it.resp = s_tdata[33:2];
        expected_cmds.push_back(next_probe_step(dut_state, cur_cfg, it));
        items_taken++;
      end
      if (m_tvalid && m_tready) begin
        got.issue = m_tdata[0];
        got.idx = m_tdata[6:1];
        got.arg = m_tdata[38:7];
        got.kind = m_tdata[40:39];
        got.finished = m_tdata[41];
        got.success = m_tdata[42];
        got.ctype = m_tdata[45:43];
        got.addr = m_tdata[61:46];
        if (expected_cmds.size() == 0) begin
          flag_mismatch("result transfer with no pending expectation");
        end else begin
          want = expected_cmds.pop_front();
          check_field("issue", 32'(got.issue), 32'(want.issue));
          check_field("cmd_index", 32'(got.idx), 32'(want.idx));
          check_field("cmd_arg", got.arg, want.arg);
          check_field("response_kind", 32'(got.kind), 32'(want.kind));
          check_field("finished", 32'(got.finished), 32'(want.finished));
          check_field("success", 32'(got.success), 32'(want.success));
          check_field("card_type", 32'(got.ctype), 32'(want.ctype));
          check_field("card_address", 32'(got.addr), 32'(want.addr));
          if (want.finished && want.success) probes_ok++;
          else if (want.finished) probes_failed++;
        end
        results_seen++;
      end
    end
  end

  task automatic push_item(input logic op, input logic to, input logic crc,
                           input logic [31:0] resp);
    probe_item_t it;
    it.opcode = op;
    it.timed_out = to;
    it.crc_failed = crc;
    it.resp = resp;
    last_plan = next_probe_step(gen_state, cur_cfg, it);
    pending_items.push_back(it);
    items_pushed++;
  endtask

  task automatic push_noise(input int count);
    repeat (count) push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), $urandom);
  endtask

  // One probe against a simulated card. Kinds: 0 absent, 1-2 MMC, 3-4 SD v1,
  // 5-6 SD v2, 7-9 SDHC. A flaky card now and then times out or fails CRC.
  task automatic run_probe();
    int          kind;
    bit          flaky;
    bit          bad;
    int          polls;
    int          polled;
    logic        to;
    logic        crc;
    logic [31:0] resp;
    kind = $urandom_range(0, 9);
    flaky = ($urandom_range(0, 3) == 0);
    polls = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cur_cfg.limit + 1)
                                       : $urandom_range(0, 3);
    polled = 0;
    push_item(OpStart, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
    while (last_plan.issue) begin
      if ($urandom_range(0, 99) < 2) begin
        push_noise(1);
      end else begin
        bad = flaky && ($urandom_range(0, 99) < 10);
        to = bad && $urandom_range(0, 1);
        crc = bad && $urandom_range(0, 1);
        resp = $urandom;
        case (last_plan.idx)
          CmdGoIdle: begin
            to = bad || (kind == 0 && $urandom_range(0, 1));
            crc = 1'($urandom_range(0, 1));
          end
          CmdIfCond: begin
            if (kind >= 5) begin
              if (!bad) resp[7:0] = CheckPattern;
            end else begin
              to = ($urandom_range(0, 7) != 0);
            end
          end
          CmdAppCmd: begin
            if (kind >= 3) begin
              resp[5] = 1'b1;
              resp[22] = bad;
            end else begin
              to = ($urandom_range(0, 3) != 0);
            end
          end
          CmdAppOp: begin
            polled++;
            resp[31] = (polled > polls);
            resp[30] = (kind >= 7);
          end
          CmdSendOp: begin
            polled++;
            if (kind == 1 || kind == 2) resp[31] = (polled > polls);
            else to = ($urandom_range(0, 3) != 0);
          end
          default: ;
        endcase
        push_item(OpFinished, to, crc, resp);
      end
    end
    // A completion while idle is ignored by the block.
    if ($urandom_range(0, 4) == 0)
      push_item(OpFinished, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
  endtask

  task automatic fill(input int count);
    int goal;
    goal = items_pushed + count;
    while (items_pushed < goal) begin
      if ($urandom_range(0, 9) == 0) push_noise($urandom_range(1, 4));
      run_probe();
    end
  endtask

  task automatic settle();
    while (pending_items.size() != 0 || s_tvalid || expected_cmds.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [23:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgAttemptLimit) cur_cfg.limit = data[6:0];
    else cur_cfg.volt = data;
  endtask

  task automatic new_setting(input logic [23:0] limit_word, input logic [23:0] volt);
    settle();
    write_reg(CfgAttemptLimit, limit_word);
    write_reg(CfgVoltageWindow, volt);
    settings_used++;
  endtask

  initial begin
    gen_state = '{ph: PhIdle, second_try: 1'b0, attempts: '0, ctype: TypeNone, addr: '0};
    dut_state = gen_state;
    cur_cfg = '{limit: LimitReset, volt: VoltReset};
    last_plan = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, at the reset settings.
    push_item(OpFinished, 1'b1, 1'b1, 32'hFFFF_FFFF);
    push_item(OpStart, 1'b0, 1'b0, 32'h0);
    push_item(OpFinished, 1'b1, 1'b0, 32'h0);
    push_item(OpFinished, 1'b0, 1'b1, 32'h0);
    push_item(OpFinished, 1'b0, 1'b0, 32'h0);
    push_item(OpFinished, 1'b0, 1'b0, 32'h0000_01AA);
    push_item(OpFinished, 1'b0, 1'b0, 32'h0);
    push_item(OpFinished, 1'b0, 1'b0, 32'h0040_0020);
    push_item(OpFinished, 1'b0, 1'b0, 32'h0000_0120);
    push_item(OpFinished, 1'b0, 1'b0, 32'h00FF_8000);
    push_item(OpFinished, 1'b0, 1'b0, 32'h0000_0020);
    push_item(OpFinished, 1'b0, 1'b0, 32'hC0FF_8000);
    push_item(OpFinished, 1'b0, 1'b0, 32'h1234_5678);
    push_item(OpFinished, 1'b0, 1'b0, 32'hBEEF_0500);
    push_item(OpFinished, 1'b0, 1'b0, 32'h0);
    push_item(OpFinished, 1'b0, 1'b0, 32'h0);
    push_item(OpFinished, 1'b0, 1'b0, 32'h0);
    // No card answers CMD0 at all.
    push_item(OpStart, 1'b0, 1'b0, 32'h0);
    push_item(OpFinished, 1'b1, 1'b0, 32'h0);
    push_item(OpFinished, 1'b1, 1'b1, 32'h0);
    // Both later resets fail, so the MMC route is taken; the probe is then
    // cut short by the next start.
    push_item(OpStart, 1'b0, 1'b0, 32'h0);
    push_item(OpFinished, 1'b0, 1'b0, 32'h0);
    push_item(OpFinished, 1'b1, 1'b0, 32'h0);
    push_item(OpFinished, 1'b1, 1'b0, 32'h0);
    push_item(OpFinished, 1'b1, 1'b0, 32'h0);
    push_item(OpFinished, 1'b1, 1'b0, 32'h0);
    push_item(OpFinished, 1'b0, 1'b0, 32'h0);
    push_item(OpFinished, 1'b0, 1'b0, 32'h80FF_8000);
    push_item(OpFinished, 1'b0, 1'b0, 32'h0);

    fill(330);
    new_setting(24'd1, 24'hFF_FFFF);
    fill(250);
    // A stretch with no gaps on either side.
    settle();
    gaps_on = 1'b0;
    new_setting(24'd127, 24'h00_0000);
    fill(250);
    settle();
    gaps_on = 1'b1;
    // The upper bits are dropped, leaving a limit of zero.
    new_setting(24'hFF_FF80, 24'($urandom_range(0, 24'hFF_FFFF)));
    fill(200);
    new_setting(24'($urandom_range(2, 8)), 24'($urandom_range(0, 24'hFF_FFFF)));
    fill(400);
    new_setting(24'($urandom_range(1, 20)), VoltReset);
    fill(350);
    settle();
    repeat (8) @(posedge clk);

    $display("Run covered %0d input transfers and %0d result transfers over %0d settings.",
             items_taken, results_seen, settings_used);
    $display("Probes ended with a card in standby: %0d; probes ended without: %0d.",
             probes_ok, probes_failed);
    if (errors == 0) begin
      $display("tb_sd_mmc_card_probe_sequencer_unit OK");
    end else begin
      $display("tb_sd_mmc_card_probe_sequencer_unit NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_sd_mmc_card_probe_sequencer_unit NOT OK");
    $finish;
  end

endmodule
